>>> src/rcsp_pkg.sv
// Shared types and constants for the command stream parser.
// Holds the byte classes, parser phases, event codes and configuration struct.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package rcsp_pkg;

  localparam int BYTE_W    = 8;
  localparam int ARG_IDX_W = 10;
  localparam int ARG_CNT_W = 11;
  localparam int LEN_W     = 21;
  localparam int LIMIT_W   = 25;

  // Upper bounds built into the parser, independent of the limit registers.
  localparam int ARG_LIMIT_BOUND    = 1024;
  localparam int COMMAND_SIZE_BOUND = 1048576;
  localparam int DEC_BASE           = 10;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [BYTE_W-1:0] CHR_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CHR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHR_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CHR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CHR_NUL    = 8'h00;

  localparam logic [ARG_CNT_W-1:0] RST_MAX_ARGS      = 11'd1024;
  localparam logic [LEN_W-1:0]     RST_MAX_ARG_BYTES = 21'd524288;
  localparam logic [LEN_W-1:0]     RST_MAX_CMD_BYTES = 21'd1048576;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_ARG_END = 2'd1,
    EV_ERROR   = 2'd2
  } event_kind_t;

  typedef enum logic {
    ERR_MALFORMED = 1'b0,
    ERR_TOO_LARGE = 1'b1
  } err_code_t;

  typedef enum logic [1:0] {
    CFG_MAX_ARGS      = 2'd0,
    CFG_MAX_ARG_BYTES = 2'd1,
    CFG_MAX_CMD_BYTES = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_WAIT      = 4'd0,
    PH_CNT_FIRST = 4'd1,
    PH_CNT_DIG   = 4'd2,
    PH_CNT_LF    = 4'd3,
    PH_DOLLAR    = 4'd4,
    PH_LEN_FIRST = 4'd5,
    PH_LEN_DIG   = 4'd6,
    PH_LEN_LF    = 4'd7,
    PH_DATA      = 4'd8,
    PH_DATA_CR   = 4'd9,
    PH_DATA_LF   = 4'd10
  } phase_t;

  // One received byte together with its precomputed class flags.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [3:0]        digit;
    logic              is_digit;
    logic              is_star;
    logic              is_dollar;
    logic              is_cr;
    logic              is_lf;
    logic              is_nul;
  } byte_class_t;

  typedef struct packed {
    logic [ARG_CNT_W-1:0] max_args;
    logic [LEN_W-1:0]     max_arg_bytes;
    logic [LEN_W-1:0]     max_cmd_bytes;
  } cfg_t;

  typedef struct packed {
    event_kind_t          kind;
    logic [BYTE_W-1:0]    payload;
    logic [ARG_IDX_W-1:0] arg_index;
    logic [LEN_W-1:0]     arg_length;
    logic                 done;
    logic [ARG_CNT_W-1:0] arg_total;
    logic [LEN_W-1:0]     consumed;
    err_code_t            err_code;
  } event_t;

endpackage

>>> src/rcsp_front.sv
// Front stage: takes raw bytes from the input stream and classifies them.
// Depends on rcsp_pkg for the byte class struct and character constants.
`timescale 1ns / 1ps

module rcsp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rcsp_pkg::BYTE_W-1:0] in_data,
  output logic                       push,
  output rcsp_pkg::byte_class_t      push_item,
  input  logic                       queue_full
);

  logic                  hold_valid_r;
  rcsp_pkg::byte_class_t hold_item_r;
  rcsp_pkg::byte_class_t cls;
  logic                  take;

  always_comb begin
    cls.data      = in_data;
    cls.digit     = 4'(in_data - rcsp_pkg::CHR_ZERO);
    cls.is_digit  = (in_data >= rcsp_pkg::CHR_ZERO) && (in_data <= rcsp_pkg::CHR_NINE);
    cls.is_star   = (in_data == rcsp_pkg::CHR_STAR);
    cls.is_dollar = (in_data == rcsp_pkg::CHR_DOLLAR);
    cls.is_cr     = (in_data == rcsp_pkg::CHR_CR);
    cls.is_lf     = (in_data == rcsp_pkg::CHR_LF);
    cls.is_nul    = (in_data == rcsp_pkg::CHR_NUL);
  end

  assign push      = hold_valid_r && !queue_full;
  assign push_item = hold_item_r;
  assign in_ready  = !hold_valid_r || !queue_full;
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (take) begin
      hold_valid_r <= 1'b1;
    end else if (push) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_item_r <= cls;
    end
  end

endmodule

>>> src/rcsp_queue.sv
// Short first-in first-out queue of classified bytes between front and back.
// Depends on rcsp_pkg for the entry type and the queue depth.
`timescale 1ns / 1ps

module rcsp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rcsp_pkg::byte_class_t push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  pop_valid,
  output rcsp_pkg::byte_class_t pop_item
);

  rcsp_pkg::byte_class_t           slot_r [rcsp_pkg::QUEUE_DEPTH];
  logic [rcsp_pkg::QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [rcsp_pkg::QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [rcsp_pkg::QUEUE_PTR_W:0]   count_r;

  assign full      = (count_r == (rcsp_pkg::QUEUE_PTR_W+1)'(rcsp_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/rcsp_back.sv
// Back stage: the parser state machine and the registered result word.
// Depends on rcsp_pkg for phases, byte classes, events and configuration.
`timescale 1ns / 1ps

module rcsp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rcsp_pkg::cfg_t        cfg,
  input  logic                  q_valid,
  input  rcsp_pkg::byte_class_t q_item,
  output logic                  q_pop,
  output logic                  evt_valid,
  input  logic                  evt_ready,
  output rcsp_pkg::event_t      evt
);

  rcsp_pkg::phase_t                 phase_r, phase_nxt;
  logic [rcsp_pkg::LEN_W-1:0]       acc_r, acc_nxt;
  logic                             ovr_r, ovr_nxt;
  logic [rcsp_pkg::ARG_CNT_W-1:0]   hdr_r, hdr_nxt;
  logic [rcsp_pkg::ARG_IDX_W-1:0]   cur_r, cur_nxt;
  logic [rcsp_pkg::LEN_W-1:0]       rem_r, rem_nxt;
  logic [rcsp_pkg::LEN_W-1:0]       decl_r, decl_nxt;
  logic [rcsp_pkg::LEN_W-1:0]       pos_r, pos_nxt;

  logic                             out_valid_r;
  rcsp_pkg::event_t                 out_evt_r;

  logic [rcsp_pkg::LEN_W-1:0]       pos_inc;
  logic [rcsp_pkg::LIMIT_W-1:0]     acc_sum;
  logic                             acc_ovf;
  logic [rcsp_pkg::LEN_W-1:0]       acc_step;
  logic [rcsp_pkg::LIMIT_W-1:0]     cmd_limit;
  logic [rcsp_pkg::LIMIT_W-1:0]     len_total;
  logic                             cnt_too_large;
  logic                             len_too_large;
  logic                             last_arg;

  logic                             err_hit;
  rcsp_pkg::err_code_t              err_code;
  logic                             emit_payload;
  logic                             emit_end;
  logic                             res_valid;
  rcsp_pkg::event_t                 res_evt;

  assign q_pop     = q_valid && (!out_valid_r || evt_ready);
  assign evt_valid = out_valid_r;
  assign evt       = out_evt_r;

  // Saturating position counter and decimal accumulation (times ten plus digit).
  assign pos_inc  = (pos_r != rcsp_pkg::LEN_MAX) ? pos_r + 1'b1 : pos_r;
  assign acc_sum  = rcsp_pkg::LIMIT_W'(acc_r) * rcsp_pkg::LIMIT_W'(rcsp_pkg::DEC_BASE)
                  + rcsp_pkg::LIMIT_W'(q_item.digit);
  assign acc_ovf  = acc_sum > rcsp_pkg::LIMIT_W'(rcsp_pkg::LEN_MAX);
  assign acc_step = acc_ovf ? rcsp_pkg::LEN_MAX : acc_sum[rcsp_pkg::LEN_W-1:0];

  assign cmd_limit = (rcsp_pkg::LIMIT_W'(cfg.max_cmd_bytes) >
                      rcsp_pkg::LIMIT_W'(rcsp_pkg::COMMAND_SIZE_BOUND))
                   ? rcsp_pkg::LIMIT_W'(rcsp_pkg::COMMAND_SIZE_BOUND)
                   : rcsp_pkg::LIMIT_W'(cfg.max_cmd_bytes);

  assign cnt_too_large = ovr_r || (acc_r == '0)
                      || (acc_r > rcsp_pkg::LEN_W'(cfg.max_args))
                      || (acc_r > rcsp_pkg::LEN_W'(rcsp_pkg::ARG_LIMIT_BOUND))
                      || (rcsp_pkg::LIMIT_W'(pos_inc) > cmd_limit);

  assign len_total = rcsp_pkg::LIMIT_W'(pos_inc) + rcsp_pkg::LIMIT_W'(acc_r)
                   + rcsp_pkg::LIMIT_W'(2);
  assign len_too_large = ovr_r || (acc_r > cfg.max_arg_bytes) || (len_total > cmd_limit);

  assign last_arg = (rcsp_pkg::ARG_CNT_W'(cur_r) + 1'b1) >= hdr_r;

  // Byte check for the current phase.
  always_comb begin
    err_hit      = 1'b0;
    err_code     = rcsp_pkg::ERR_MALFORMED;
    emit_payload = 1'b0;
    emit_end     = 1'b0;
    case (phase_r)
      rcsp_pkg::PH_WAIT: begin
        err_hit = !q_item.is_star;
      end
      rcsp_pkg::PH_CNT_FIRST, rcsp_pkg::PH_LEN_FIRST: begin
        err_hit = !q_item.is_digit;
      end
      rcsp_pkg::PH_CNT_DIG, rcsp_pkg::PH_LEN_DIG: begin
        err_hit = !q_item.is_digit && !q_item.is_cr;
      end
      rcsp_pkg::PH_CNT_LF: begin
        if (!q_item.is_lf) begin
          err_hit = 1'b1;
        end else if (cnt_too_large) begin
          err_hit  = 1'b1;
          err_code = rcsp_pkg::ERR_TOO_LARGE;
        end
      end
      rcsp_pkg::PH_DOLLAR: begin
        err_hit = !q_item.is_dollar;
      end
      rcsp_pkg::PH_LEN_LF: begin
        if (!q_item.is_lf) begin
          err_hit = 1'b1;
        end else if (len_too_large) begin
          err_hit  = 1'b1;
          err_code = rcsp_pkg::ERR_TOO_LARGE;
        end
      end
      rcsp_pkg::PH_DATA: begin
        err_hit      = q_item.is_nul;
        emit_payload = !q_item.is_nul;
      end
      rcsp_pkg::PH_DATA_CR: begin
        err_hit = !q_item.is_cr;
      end
      rcsp_pkg::PH_DATA_LF: begin
        err_hit  = !q_item.is_lf;
        emit_end = q_item.is_lf;
      end
      default: begin
        err_hit = 1'b0;
      end
    endcase
  end

  // Next state of the parser.
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    ovr_nxt   = ovr_r;
    hdr_nxt   = hdr_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    decl_nxt  = decl_r;
    pos_nxt   = pos_inc;
    if (err_hit) begin
      phase_nxt = rcsp_pkg::PH_WAIT;
      acc_nxt   = '0;
      ovr_nxt   = 1'b0;
      hdr_nxt   = '0;
      cur_nxt   = '0;
      rem_nxt   = '0;
      decl_nxt  = '0;
      pos_nxt   = '0;
    end else begin
      case (phase_r)
        rcsp_pkg::PH_WAIT: begin
          pos_nxt   = rcsp_pkg::LEN_W'(1);
          acc_nxt   = '0;
          ovr_nxt   = 1'b0;
          phase_nxt = rcsp_pkg::PH_CNT_FIRST;
        end
        rcsp_pkg::PH_CNT_FIRST: begin
          acc_nxt   = acc_step;
          ovr_nxt   = ovr_r | acc_ovf;
          phase_nxt = rcsp_pkg::PH_CNT_DIG;
        end
        rcsp_pkg::PH_LEN_FIRST: begin
          acc_nxt   = acc_step;
          ovr_nxt   = ovr_r | acc_ovf;
          phase_nxt = rcsp_pkg::PH_LEN_DIG;
        end
        rcsp_pkg::PH_CNT_DIG: begin
          if (q_item.is_digit) begin
            acc_nxt = acc_step;
            ovr_nxt = ovr_r | acc_ovf;
          end else begin
            phase_nxt = rcsp_pkg::PH_CNT_LF;
          end
        end
        rcsp_pkg::PH_LEN_DIG: begin
          if (q_item.is_digit) begin
            acc_nxt = acc_step;
            ovr_nxt = ovr_r | acc_ovf;
          end else begin
            phase_nxt = rcsp_pkg::PH_LEN_LF;
          end
        end
        rcsp_pkg::PH_CNT_LF: begin
          hdr_nxt   = acc_r[rcsp_pkg::ARG_CNT_W-1:0];
          cur_nxt   = '0;
          phase_nxt = rcsp_pkg::PH_DOLLAR;
        end
        rcsp_pkg::PH_DOLLAR: begin
          acc_nxt   = '0;
          ovr_nxt   = 1'b0;
          phase_nxt = rcsp_pkg::PH_LEN_FIRST;
        end
        rcsp_pkg::PH_LEN_LF: begin
          decl_nxt  = acc_r;
          rem_nxt   = acc_r;
          phase_nxt = (acc_r != '0) ? rcsp_pkg::PH_DATA : rcsp_pkg::PH_DATA_CR;
        end
        rcsp_pkg::PH_DATA: begin
          rem_nxt = rem_r - 1'b1;
          if (rem_r == rcsp_pkg::LEN_W'(1)) begin
            phase_nxt = rcsp_pkg::PH_DATA_CR;
          end
        end
        rcsp_pkg::PH_DATA_CR: begin
          phase_nxt = rcsp_pkg::PH_DATA_LF;
        end
        rcsp_pkg::PH_DATA_LF: begin
          if (last_arg) begin
            phase_nxt = rcsp_pkg::PH_WAIT;
            acc_nxt   = '0;
            ovr_nxt   = 1'b0;
            hdr_nxt   = '0;
            cur_nxt   = '0;
            rem_nxt   = '0;
            decl_nxt  = '0;
            pos_nxt   = '0;
          end else begin
            cur_nxt   = cur_r + 1'b1;
            decl_nxt  = '0;
            phase_nxt = rcsp_pkg::PH_DOLLAR;
          end
        end
        default: begin
          phase_nxt = rcsp_pkg::PH_WAIT;
          acc_nxt   = '0;
          ovr_nxt   = 1'b0;
          hdr_nxt   = '0;
          cur_nxt   = '0;
          rem_nxt   = '0;
          decl_nxt  = '0;
          pos_nxt   = '0;
        end
      endcase
    end
  end

  // Result word for this byte; fields that do not apply to the event stay zero.
  always_comb begin
    res_valid          = err_hit || emit_payload || emit_end;
    res_evt.kind       = err_hit ? rcsp_pkg::EV_ERROR
                       : (emit_end ? rcsp_pkg::EV_ARG_END : rcsp_pkg::EV_PAYLOAD);
    res_evt.payload    = emit_payload ? q_item.data : '0;
    res_evt.arg_index  = cur_r;
    res_evt.arg_length = emit_end ? decl_r : '0;
    res_evt.done       = emit_end && last_arg;
    res_evt.arg_total  = (emit_end && last_arg) ? hdr_r : '0;
    res_evt.consumed   = (emit_end && last_arg) ? pos_inc : '0;
    res_evt.err_code   = err_hit ? err_code : rcsp_pkg::ERR_MALFORMED;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rcsp_pkg::PH_WAIT;
      acc_r       <= '0;
      ovr_r       <= 1'b0;
      hdr_r       <= '0;
      cur_r       <= '0;
      rem_r       <= '0;
      decl_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        ovr_r   <= ovr_nxt;
        hdr_r   <= hdr_nxt;
        cur_r   <= cur_nxt;
        rem_r   <= rem_nxt;
        decl_r  <= decl_nxt;
        pos_r   <= pos_nxt;
      end
      if (q_pop && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (evt_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_evt_r <= res_evt;
    end
  end

endmodule

>>> src/resp_command_stream_parser.sv
// Top level of the command stream parser: limit registers, front, queue and back.
// Depends on rcsp_pkg, rcsp_front, rcsp_queue and rcsp_back.
`timescale 1ns / 1ps

// Channel  | Direction | Word contents
// ---------+-----------+---------------------------------------------------------
// in_      | slave     | tdata: in_byte [7:0]
// out_     | master    | tdata: payload_byte, argument_index, argument_length,
//          |           |        argument_total, consumed_bytes, error_code
//          |           | tuser: event_kind; tlast: command_done
// cfg_     | slave     | cfg_index selects the limit register, cfg_data its value
//
// The parser takes one byte word per clock cycle while in_tready is high and gives
// at most one result word per byte; each byte passes through the classify register,
// which writes the queue, then the parser step loads its result into the output register.
// Reset is synchronous and active low; it returns the parser to waiting for a star
// and loads the default limits.
// A stalled output holds its word; the four-entry queue and then the classify
// register fill, and only then does in_tready drop.
module resp_command_stream_parser (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte

  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [17:8] argument_index, [38:18] argument_length,
  // [49:39] argument_total, [70:50] consumed_bytes, [71] error_code
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast,  // command_done

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  rcsp_pkg::cfg_t        cfg_r;
  logic                  push;
  rcsp_pkg::byte_class_t push_item;
  logic                  queue_full;
  logic                  q_valid;
  logic                  q_pop;
  rcsp_pkg::byte_class_t q_item;
  rcsp_pkg::event_t      evt;

  // Limit registers are always writable; writes to an index past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_args      <= rcsp_pkg::RST_MAX_ARGS;
      cfg_r.max_arg_bytes <= rcsp_pkg::RST_MAX_ARG_BYTES;
      cfg_r.max_cmd_bytes <= rcsp_pkg::RST_MAX_CMD_BYTES;
    end else if (cfg_valid) begin
      case (rcsp_pkg::cfg_idx_t'(cfg_index))
        rcsp_pkg::CFG_MAX_ARGS: begin
          cfg_r.max_args <= cfg_data[rcsp_pkg::ARG_CNT_W-1:0];
        end
        rcsp_pkg::CFG_MAX_ARG_BYTES: begin
          cfg_r.max_arg_bytes <= cfg_data;
        end
        rcsp_pkg::CFG_MAX_CMD_BYTES: begin
          cfg_r.max_cmd_bytes <= cfg_data;
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // The front classifies each byte so the parser step only tests flags.
  rcsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  rcsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  // The back runs the parser and owns the output register.
  rcsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .evt_valid (out_tvalid),
    .evt_ready (out_tready),
    .evt       (evt)
  );

  assign out_tdata = {evt.err_code, evt.consumed, evt.arg_total, evt.arg_length,
                      evt.arg_index, evt.payload};
  assign out_tuser = evt.kind;
  assign out_tlast = evt.done;

endmodule
